@@ src/pattern_data_expander_macros.svh @@
// ----------------------------------------------------------------------------
// Pattern data expander assertion macros
// Shared assertion forms for the checker of the pattern data expander.
// ----------------------------------------------------------------------------
`ifndef PATTERN_DATA_EXPANDER_MACROS_SVH
`define PATTERN_DATA_EXPANDER_MACROS_SVH

// A property that is checked only while the block is out of reset.
`define PDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property that is also checked while reset is applied.
`define PDE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pde_pkg.sv @@
// ----------------------------------------------------------------------------
// Pattern data expander package
// Shared widths, result kinds and the command descriptor type.
// ----------------------------------------------------------------------------
package pde_pkg;

  localparam int ARG_W  = 32;
  localparam int LEN_W  = 64;
  localparam int DIST_W = 33;
  localparam int OUT_DATA_W = 112;

  localparam logic [1:0] K_LIT  = 2'd0;
  localparam logic [1:0] K_ZERO = 2'd1;
  localparam logic [1:0] K_COPY = 2'd2;
  localparam logic [1:0] K_BAD  = 2'd3;

  // Results of one input item: an optional literal, then an optional command
  // whose length is mul_a * mul_b + add_c.
  typedef struct packed {
    logic              lit_en;
    logic [7:0]        lit_val;
    logic              cmd_en;
    logic [1:0]        cmd_kind;
    logic [ARG_W-1:0]  mul_a;
    logic [ARG_W-1:0]  mul_b;
    logic [ARG_W-1:0]  add_c;
    logic [DIST_W-1:0] copy_dist;
  } desc_t;

endpackage

@@ src/pattern_data_expander.sv @@
// ----------------------------------------------------------------------------
// Pattern data expander
// Decodes a packed pattern data byte stream into literal, zero run and
// back copy commands.
// ----------------------------------------------------------------------------
// The block takes one packed byte per clock cycle unless the output side
// holds it back. Each byte gives zero, one or two result items, and the
// result port sends one item per cycle while out_tready is high, so a byte
// that gives a literal followed by a back copy or a zero run holds the
// output for both items and can make the input pause when bytes follow back
// to back. The first result of a byte passes two registers on its way to the
// output: the decoder registers a command descriptor, and the second stage
// forms the run length with one 32 by 32 multiplier and an add before the
// result register. An unknown opcode gives one error item, and the bytes
// after it are dropped up to the last byte.
module pattern_data_expander (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // data_byte
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // literal_value [7:0], run_length [71:8], copy_distance [104:72], zeros above
  output logic [pde_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                     out_tuser,  // kind
  output logic                           out_tlast
);

  logic           d_valid;
  logic           d_ready;
  pde_pkg::desc_t d_desc;

  pde_decoder u_decoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .d_valid  (d_valid),
    .d_desc   (d_desc),
    .d_ready  (d_ready)
  );

  pde_len_stage u_len_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .d_valid    (d_valid),
    .d_desc     (d_desc),
    .d_ready    (d_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ src/pde_decoder.sv @@
// ----------------------------------------------------------------------------
// Pattern data expander decoder
// Parses opcode and argument bytes and registers the command descriptor.
// ----------------------------------------------------------------------------
module pde_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          in_ready,
  output logic          d_valid,
  output pde_pkg::desc_t d_desc,
  input  logic          d_ready
);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_COUNT_ARG  = 3'd1;
  localparam logic [2:0] PH_CUSTOM_ARG = 3'd2;
  localparam logic [2:0] PH_REPEAT_ARG = 3'd3;
  localparam logic [2:0] PH_LIT_PLAIN  = 3'd4;
  localparam logic [2:0] PH_LIT_REPEAT = 3'd5;
  localparam logic [2:0] PH_COMMON     = 3'd6;
  localparam logic [2:0] PH_CUSTOM     = 3'd7;

  localparam logic [2:0] OP_ZERO     = 3'd0;
  localparam logic [2:0] OP_COPY     = 3'd1;
  localparam logic [2:0] OP_REP      = 3'd2;
  localparam logic [2:0] OP_ILV_COPY = 3'd3;
  localparam logic [2:0] OP_ILV_ZERO = 3'd4;

  localparam int AW = pde_pkg::ARG_W;
  localparam int DW = pde_pkg::DIST_W;

  logic [2:0]    ph_r, ph_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [AW-1:0] bc_r, bc_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [AW-1:0] cus_r, cus_nxt;
  logic [AW-1:0] rep_r, rep_nxt;
  logic [AW-1:0] left_r, left_nxt;
  logic          disc_r, disc_nxt;
  logic          d_valid_r, d_valid_nxt;
  pde_pkg::desc_t desc_r, desc_nxt;

  logic [AW-1:0] argv;
  logic [AW-1:0] left_dec;
  logic [AW-1:0] rep_dec;
  logic          bo_go;
  logic          ac_go;
  logic          accept;

  assign in_ready = !d_valid_r || d_ready;
  assign accept   = in_valid && in_ready;
  assign d_valid  = d_valid_r;
  assign d_desc   = desc_r;

  always_comb begin
    ph_nxt   = ph_r;
    op_nxt   = op_r;
    bc_nxt   = bc_r;
    acc_nxt  = acc_r;
    cus_nxt  = cus_r;
    rep_nxt  = rep_r;
    left_nxt = left_r;
    disc_nxt = disc_r;
    desc_nxt = '0;
    bo_go    = 1'b0;
    ac_go    = 1'b0;
    argv     = {acc_r[AW-8:0], in_byte[6:0]};
    left_dec = left_r - AW'(1);
    rep_dec  = rep_r - AW'(1);

    if (disc_r) begin
      if (in_last) begin
        disc_nxt = 1'b0;
      end
    end else begin
      case (ph_r)
        PH_IDLE: begin
          op_nxt = in_byte[7:5];
          if (in_byte[7:5] > OP_ILV_ZERO) begin
            desc_nxt.cmd_en   = 1'b1;
            desc_nxt.cmd_kind = pde_pkg::K_BAD;
            disc_nxt = 1'b1;
            ph_nxt   = PH_IDLE;
          end else if (in_byte[4:0] == 5'd0) begin
            acc_nxt = '0;
            ph_nxt  = PH_COUNT_ARG;
          end else begin
            bc_nxt = AW'(in_byte[4:0]);
            bo_go  = 1'b1;
          end
        end
        PH_COUNT_ARG, PH_CUSTOM_ARG, PH_REPEAT_ARG: begin
          if (in_byte[7]) begin
            acc_nxt = argv;
          end else begin
            acc_nxt = '0;
            if (ph_r == PH_COUNT_ARG) begin
              bc_nxt = argv;
              bo_go  = 1'b1;
            end else if (ph_r == PH_CUSTOM_ARG) begin
              cus_nxt = argv;
              ph_nxt  = PH_REPEAT_ARG;
            end else begin
              rep_nxt = argv;
              if (op_r == OP_REP) begin
                left_nxt = bc_r;
                ph_nxt   = (bc_r != '0) ? PH_LIT_REPEAT : PH_IDLE;
              end else if (op_r == OP_ILV_COPY) begin
                if (bc_r != '0) begin
                  left_nxt = bc_r;
                  ph_nxt   = PH_COMMON;
                end else begin
                  ac_go = 1'b1;
                end
              end else if (cus_r == '0) begin
                if (bc_r != '0) begin
                  desc_nxt.cmd_en   = 1'b1;
                  desc_nxt.cmd_kind = pde_pkg::K_ZERO;
                  desc_nxt.mul_a    = bc_r;
                  desc_nxt.mul_b    = argv;
                  desc_nxt.add_c    = bc_r;
                end
                ph_nxt = PH_IDLE;
              end else begin
                if (bc_r != '0) begin
                  desc_nxt.cmd_en   = 1'b1;
                  desc_nxt.cmd_kind = pde_pkg::K_ZERO;
                  desc_nxt.add_c    = bc_r;
                end
                left_nxt = cus_r;
                ph_nxt   = (argv != '0) ? PH_CUSTOM : PH_IDLE;
              end
            end
          end
        end
        PH_LIT_PLAIN: begin
          desc_nxt.lit_en  = 1'b1;
          desc_nxt.lit_val = in_byte;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            ph_nxt = PH_IDLE;
          end
        end
        PH_LIT_REPEAT: begin
          desc_nxt.lit_en  = 1'b1;
          desc_nxt.lit_val = in_byte;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            if (bc_r != '0 && rep_r != '0) begin
              desc_nxt.cmd_en    = 1'b1;
              desc_nxt.cmd_kind  = pde_pkg::K_COPY;
              desc_nxt.mul_a     = bc_r;
              desc_nxt.mul_b     = rep_r;
              desc_nxt.copy_dist = DW'(bc_r);
            end
            ph_nxt = PH_IDLE;
          end
        end
        PH_COMMON: begin
          desc_nxt.lit_en  = 1'b1;
          desc_nxt.lit_val = in_byte;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            ac_go = 1'b1;
          end
        end
        PH_CUSTOM: begin
          desc_nxt.lit_en  = 1'b1;
          desc_nxt.lit_val = in_byte;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            rep_nxt = rep_dec;
            if (bc_r != '0) begin
              desc_nxt.cmd_en = 1'b1;
              desc_nxt.add_c  = bc_r;
              if (op_r == OP_ILV_COPY) begin
                desc_nxt.cmd_kind  = pde_pkg::K_COPY;
                desc_nxt.copy_dist = DW'(bc_r) + DW'(cus_r);
              end else begin
                desc_nxt.cmd_kind = pde_pkg::K_ZERO;
              end
            end
            left_nxt = cus_r;
            if (rep_dec == '0) begin
              ph_nxt = PH_IDLE;
            end
          end
        end
        default: begin
          ph_nxt = PH_IDLE;
        end
      endcase

      // Start of a command once its block count is known.
      if (bo_go) begin
        case (op_nxt)
          OP_ZERO: begin
            if (bc_nxt != '0) begin
              desc_nxt.cmd_en   = 1'b1;
              desc_nxt.cmd_kind = pde_pkg::K_ZERO;
              desc_nxt.add_c    = bc_nxt;
            end
            ph_nxt = PH_IDLE;
          end
          OP_COPY: begin
            left_nxt = bc_nxt;
            ph_nxt   = (bc_nxt != '0) ? PH_LIT_PLAIN : PH_IDLE;
          end
          OP_REP: begin
            ph_nxt = PH_REPEAT_ARG;
          end
          default: begin
            ph_nxt = PH_CUSTOM_ARG;
          end
        endcase
      end

      // End of the common part of an interleaved block copy.
      if (ac_go) begin
        if (rep_nxt == '0) begin
          ph_nxt = PH_IDLE;
        end else if (cus_r == '0) begin
          if (bc_r != '0) begin
            desc_nxt.cmd_en    = 1'b1;
            desc_nxt.cmd_kind  = pde_pkg::K_COPY;
            desc_nxt.mul_a     = bc_r;
            desc_nxt.mul_b     = rep_nxt;
            desc_nxt.copy_dist = DW'(bc_r);
          end
          ph_nxt = PH_IDLE;
        end else begin
          left_nxt = cus_r;
          ph_nxt   = PH_CUSTOM;
        end
      end

      if (in_last) begin
        disc_nxt = 1'b0;
        ph_nxt   = PH_IDLE;
        acc_nxt  = '0;
      end
    end
  end

  always_comb begin
    if (accept && (desc_nxt.lit_en || desc_nxt.cmd_en)) begin
      d_valid_nxt = 1'b1;
    end else if (d_ready) begin
      d_valid_nxt = 1'b0;
    end else begin
      d_valid_nxt = d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_IDLE;
      op_r      <= OP_ZERO;
      bc_r      <= '0;
      acc_r     <= '0;
      cus_r     <= '0;
      rep_r     <= '0;
      left_r    <= '0;
      disc_r    <= 1'b0;
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= d_valid_nxt;
      if (accept) begin
        ph_r   <= ph_nxt;
        op_r   <= op_nxt;
        bc_r   <= bc_nxt;
        acc_r  <= acc_nxt;
        cus_r  <= cus_nxt;
        rep_r  <= rep_nxt;
        left_r <= left_nxt;
        disc_r <= disc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r <= desc_nxt;
    end
  end

endmodule

@@ src/pde_len_stage.sv @@
// ----------------------------------------------------------------------------
// Pattern data expander length stage
// Computes the command length and sends the results of each item in order.
// ----------------------------------------------------------------------------
module pde_len_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            d_valid,
  input  pde_pkg::desc_t                  d_desc,
  output logic                            d_ready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pde_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast
);

  localparam int LW = pde_pkg::LEN_W;
  localparam int DW = pde_pkg::DIST_W;
  localparam int PAD_W = pde_pkg::OUT_DATA_W - 8 - LW - DW;

  logic          v_r, v_nxt;
  logic          lit_done_r, lit_done_nxt;
  logic          lit_en_r;
  logic [7:0]    lit_val_r;
  logic          cmd_en_r;
  logic [1:0]    kind_r;
  logic [LW-1:0] len_r;
  logic [DW-1:0] dist_r;
  logic [LW-1:0] len_nxt;
  logic          sending_lit;
  logic          done;
  logic          load;

  assign sending_lit = lit_en_r && !lit_done_r;
  assign out_tvalid  = v_r;
  assign out_tlast   = sending_lit ? !cmd_en_r : 1'b1;
  assign out_tuser   = sending_lit ? pde_pkg::K_LIT : kind_r;
  assign out_tdata   = sending_lit ? {PAD_W'(0), DW'(0), LW'(0), lit_val_r}
                                   : {PAD_W'(0), dist_r, len_r, 8'd0};

  assign done    = v_r && out_tready && out_tlast;
  assign d_ready = !v_r || done;
  assign load    = d_valid && d_ready;

  assign len_nxt = LW'(d_desc.mul_a) * LW'(d_desc.mul_b) + LW'(d_desc.add_c);

  always_comb begin
    if (load) begin
      v_nxt = 1'b1;
    end else if (done) begin
      v_nxt = 1'b0;
    end else begin
      v_nxt = v_r;
    end
    if (load) begin
      lit_done_nxt = 1'b0;
    end else if (v_r && out_tready && sending_lit) begin
      lit_done_nxt = 1'b1;
    end else begin
      lit_done_nxt = lit_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r        <= 1'b0;
      lit_done_r <= 1'b0;
    end else begin
      v_r        <= v_nxt;
      lit_done_r <= lit_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lit_en_r  <= d_desc.lit_en;
      lit_val_r <= d_desc.lit_val;
      cmd_en_r  <= d_desc.cmd_en;
      kind_r    <= d_desc.cmd_kind;
      len_r     <= len_nxt;
      dist_r    <= d_desc.copy_dist;
    end
  end

endmodule

@@ src/pde_checker.sv @@
// ----------------------------------------------------------------------------
// Pattern data expander checker
// Port-level assertions on the result channel of the pattern data expander.
// ----------------------------------------------------------------------------
`include "pattern_data_expander_macros.svh"

module pde_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pde_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                     out_tuser,
  input logic                           out_tlast
);

  // A result item waiting on the output holds its contents.
  `PDE_ASSERT(a_hold, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "Stalled result item changed.")
  // A literal item carries no length and no distance.
  `PDE_ASSERT(a_lit_clean, out_tvalid && out_tuser == pde_pkg::K_LIT |-> out_tdata[104:8] == '0, "Literal item has length or distance.")
  // Zero runs and back copies are never empty.
  `PDE_ASSERT(a_run_nonzero, out_tvalid && (out_tuser == pde_pkg::K_ZERO || out_tuser == pde_pkg::K_COPY) |-> out_tdata[71:8] != '0, "Empty run item sent.")
  // Only a literal can be followed by another item of the same byte.
  `PDE_ASSERT(a_first_is_lit, out_tvalid && !out_tlast |-> out_tuser == pde_pkg::K_LIT, "Non-literal item not marked last.")
  // The output is empty right after reset.
  `PDE_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "Result valid after reset.")

endmodule

bind pattern_data_expander pde_checker u_pde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
